[hw/rtl/cbe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared types, constants and helpers for the cubic-bezier easing solver.
// ----------------------------------------------------------------------------
package cbe_pkg;

  // Default values for the top-level parameters.
  localparam int BISECT_STEPS_DEF    = 20;
  localparam int PARAM_FRAC_BITS_DEF = 24;

  // Working format of the curve parameter inside the evaluator.
  localparam int WORK_FRAC = 30;

  // Field widths.
  localparam int PROG_W  = 18;
  localparam int FRAC_W  = 16;
  localparam int CTRLX_W = 17;
  localparam int CFG_W   = 18;
  localparam int IDX_W   = 2;

  // Three times a control coordinate, signed.
  localparam int COEF_W = 20;
  // Control coordinate times a basis term.
  localparam int PROD_W = COEF_W + WORK_FRAC + 1;
  // Full curve value in signed Q46.
  localparam int V_W    = 53;
  // Rounded result before saturation.
  localparam int RND_W  = V_W - WORK_FRAC;

  // Latency of the curve evaluator.
  localparam int CE_LAT = 3;

  localparam logic [CTRLX_W-1:0] X_ONE = CTRLX_W'(65536);

  localparam logic signed [V_W-1:0]   ROUND_BIAS = V_W'(1) << (WORK_FRAC - 1);
  localparam logic signed [RND_W-1:0] OUT_MAX    = RND_W'(131071);
  localparam logic signed [RND_W-1:0] OUT_MIN    = -RND_W'(131072);
  localparam logic [PROG_W-1:0]       EASED_ONE  = PROG_W'(65536);

  typedef logic signed [COEF_W-1:0] cbe_coef_t;

  // Reset values of the stored coefficients (three times each control value).
  localparam cbe_coef_t KX1_RST = COEF_W'(3 * 16384);
  localparam cbe_coef_t KY1_RST = COEF_W'(3 * 6554);
  localparam cbe_coef_t KX2_RST = COEF_W'(3 * 16384);
  localparam cbe_coef_t KY2_RST = COEF_W'(3 * 65536);

  typedef enum logic [IDX_W-1:0] {
    REG_CTRL_X1 = 2'd0,
    REG_CTRL_Y1 = 2'd1,
    REG_CTRL_X2 = 2'd2,
    REG_CTRL_Y2 = 2'd3
  } cbe_reg_e;

  // How an item's result is formed.
  typedef enum logic [1:0] {
    CLS_ZERO  = 2'd0,
    CLS_ONE   = 2'd1,
    CLS_CURVE = 2'd2
  } cbe_cls_e;

  typedef struct packed {
    logic     valid;
    cbe_cls_e cls;
  } cbe_ctl_t;

  // Products that make up one curve value.
  typedef struct packed {
    logic signed [PROD_W-1:0] m1;
    logic signed [PROD_W-1:0] m2;
    logic [WORK_FRAC-1:0]     b3;
  } cbe_terms_t;

  // Clamp an x coordinate to one and multiply by three.
  function automatic cbe_coef_t cbe_triple_x(input logic [CFG_W-1:0] data);
    logic [CTRLX_W-1:0] x;
    logic [CTRLX_W-1:0] xc;
    x  = data[CTRLX_W-1:0];
    xc = (x > X_ONE) ? X_ONE : x;
    return COEF_W'({xc, 1'b0}) + COEF_W'(xc);
  endfunction

  // Take a y coordinate as signed and multiply by three.
  function automatic cbe_coef_t cbe_triple_y(input logic [CFG_W-1:0] data);
    cbe_coef_t y;
    y = {{(COEF_W - CFG_W){data[CFG_W-1]}}, data};
    return (y <<< 1) + y;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/cbe_curve_eval.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbe_curve_eval
// Three-stage evaluator of the Bernstein terms of one curve coordinate.
// ----------------------------------------------------------------------------
module cbe_curve_eval #(
  parameter int PFB = 24
) (
  input  wire logic               clk,
  input  wire logic [PFB-1:0]     t,
  input  wire cbe_pkg::cbe_coef_t k1,
  input  wire cbe_pkg::cbe_coef_t k2,
  output cbe_pkg::cbe_terms_t     terms
);
  import cbe_pkg::*;

  logic [WORK_FRAC-1:0] tq;
  logic [WORK_FRAC:0]   uq;

  // The parameter is always below one, so tq fits in WORK_FRAC bits.
  generate
    if (PFB >= WORK_FRAC) begin : g_shr
      assign tq = t[PFB-1 -: WORK_FRAC];
    end else begin : g_shl
      assign tq = {t, {(WORK_FRAC - PFB){1'b0}}};
    end
  endgenerate

  assign uq = (WORK_FRAC + 1)'(1) << WORK_FRAC;
  logic [WORK_FRAC:0] uq_c;
  assign uq_c = uq - {1'b0, tq};

  // Stage 1: squares.
  logic [2*WORK_FRAC-1:0] prod_tt;
  logic [2*WORK_FRAC+1:0] prod_uu;
  logic [WORK_FRAC-1:0]   s1_tq;
  logic [WORK_FRAC:0]     s1_uq;
  logic [WORK_FRAC-1:0]   s1_t2;
  logic [WORK_FRAC:0]     s1_u2;

  assign prod_tt = tq * tq;
  assign prod_uu = uq_c * uq_c;

  always_ff @(posedge clk) begin
    s1_tq <= tq;
    s1_uq <= uq_c;
    s1_t2 <= prod_tt[2*WORK_FRAC-1:WORK_FRAC];
    s1_u2 <= prod_uu[2*WORK_FRAC:WORK_FRAC];
  end

  // Stage 2: cubic basis terms.
  logic [2*WORK_FRAC:0]   prod_b1;
  logic [2*WORK_FRAC:0]   prod_b2;
  logic [2*WORK_FRAC-1:0] prod_b3;
  logic [WORK_FRAC-1:0]   s2_b1;
  logic [WORK_FRAC-1:0]   s2_b2;
  logic [WORK_FRAC-1:0]   s2_b3;

  assign prod_b1 = s1_u2 * s1_tq;
  assign prod_b2 = s1_uq * s1_t2;
  assign prod_b3 = s1_t2 * s1_tq;

  always_ff @(posedge clk) begin
    s2_b1 <= prod_b1[2*WORK_FRAC-1:WORK_FRAC];
    s2_b2 <= prod_b2[2*WORK_FRAC-1:WORK_FRAC];
    s2_b3 <= prod_b3[2*WORK_FRAC-1:WORK_FRAC];
  end

  // Stage 3: weight by the control coefficients.
  logic signed [PROD_W-1:0] prod_m1;
  logic signed [PROD_W-1:0] prod_m2;

  assign prod_m1 = k1 * $signed({1'b0, s2_b1});
  assign prod_m2 = k2 * $signed({1'b0, s2_b2});

  always_ff @(posedge clk) begin
    terms.m1 <= prod_m1;
    terms.m2 <= prod_m2;
    terms.b3 <= s2_b3;
  end

endmodule
`default_nettype wire

[hw/rtl/cbe_bisect_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbe_bisect_step
// One halving of the parameter interval: evaluates x at the midpoint and
// keeps the half that still brackets the target progress.
// ----------------------------------------------------------------------------
module cbe_bisect_step #(
  parameter int PFB = 24
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire cbe_pkg::cbe_ctl_t                  ctl_in,
  input  wire logic [cbe_pkg::FRAC_W-1:0]         p_in,
  input  wire logic [PFB:0]                       lo_in,
  input  wire logic [PFB:0]                       hi_in,
  input  wire cbe_pkg::cbe_coef_t                 k1,
  input  wire cbe_pkg::cbe_coef_t                 k2,
  output cbe_pkg::cbe_ctl_t                       ctl_out,
  output logic [cbe_pkg::FRAC_W-1:0]              p_out,
  output logic [PFB:0]                            lo_out,
  output logic [PFB:0]                            hi_out
);
  import cbe_pkg::*;

  logic [PFB+1:0] sum_lh;
  logic [PFB-1:0] mid;

  assign sum_lh = {1'b0, lo_in} + {1'b0, hi_in};
  assign mid    = sum_lh[PFB:1];

  cbe_terms_t terms;

  cbe_curve_eval #(
    .PFB (PFB)
  ) u_eval (
    .clk   (clk),
    .t     (mid),
    .k1    (k1),
    .k2    (k2),
    .terms (terms)
  );

  // Item state rides alongside the evaluator.
  cbe_ctl_t          ctl_d [CE_LAT];
  logic [FRAC_W-1:0] p_d   [CE_LAT];
  logic [PFB:0]      lo_d  [CE_LAT];
  logic [PFB:0]      hi_d  [CE_LAT];
  logic [PFB-1:0]    mid_d [CE_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CE_LAT; i++) begin
        ctl_d[i] <= '0;
      end
    end else begin
      ctl_d[0] <= ctl_in;
      for (int i = 1; i < CE_LAT; i++) begin
        ctl_d[i] <= ctl_d[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    p_d[0]   <= p_in;
    lo_d[0]  <= lo_in;
    hi_d[0]  <= hi_in;
    mid_d[0] <= mid;
    for (int i = 1; i < CE_LAT; i++) begin
      p_d[i]   <= p_d[i-1];
      lo_d[i]  <= lo_d[i-1];
      hi_d[i]  <= hi_d[i-1];
      mid_d[i] <= mid_d[i-1];
    end
  end

  // x(mid) against the target, both in Q46.
  logic signed [V_W-1:0] v;
  logic signed [V_W-1:0] target;
  logic                  below;

  assign v = {{(V_W - PROD_W){terms.m1[PROD_W-1]}}, terms.m1}
           + {{(V_W - PROD_W){terms.m2[PROD_W-1]}}, terms.m2}
           + {{(V_W - WORK_FRAC - FRAC_W){1'b0}}, terms.b3, {FRAC_W{1'b0}}};
  assign target = {{(V_W - FRAC_W - WORK_FRAC){1'b0}}, p_d[CE_LAT-1],
                   {WORK_FRAC{1'b0}}};
  assign below  = v < target;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_d[CE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    p_out  <= p_d[CE_LAT-1];
    lo_out <= below ? {1'b0, mid_d[CE_LAT-1]} : lo_d[CE_LAT-1];
    hi_out <= below ? hi_d[CE_LAT-1] : {1'b0, mid_d[CE_LAT-1]};
  end

endmodule
`default_nettype wire

[hw/rtl/cbe_finish.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbe_finish
// Evaluates y at the midpoint of the final interval, rounds to Q16,
// saturates, and substitutes the fixed answers for progress outside (0,1).
// ----------------------------------------------------------------------------
module cbe_finish #(
  parameter int PFB = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cbe_pkg::cbe_ctl_t           ctl_in,
  input  wire logic [PFB:0]                lo_in,
  input  wire logic [PFB:0]                hi_in,
  input  wire cbe_pkg::cbe_coef_t          k1,
  input  wire cbe_pkg::cbe_coef_t          k2,
  output logic                             done,
  output logic [cbe_pkg::PROG_W-1:0]       eased_out
);
  import cbe_pkg::*;

  logic [PFB+1:0] sum_lh;
  logic [PFB-1:0] t_fin;

  assign sum_lh = {1'b0, lo_in} + {1'b0, hi_in};
  assign t_fin  = sum_lh[PFB:1];

  cbe_terms_t terms;

  cbe_curve_eval #(
    .PFB (PFB)
  ) u_eval (
    .clk   (clk),
    .t     (t_fin),
    .k1    (k1),
    .k2    (k2),
    .terms (terms)
  );

  cbe_ctl_t ctl_d [CE_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CE_LAT; i++) begin
        ctl_d[i] <= '0;
      end
    end else begin
      ctl_d[0] <= ctl_in;
      for (int i = 1; i < CE_LAT; i++) begin
        ctl_d[i] <= ctl_d[i-1];
      end
    end
  end

  // Round half up from Q46 to Q16, then clip to the 18-bit signed range.
  logic signed [V_W-1:0]   v_bias;
  logic signed [RND_W-1:0] rnd;
  logic [PROG_W-1:0]       sat;
  logic [PROG_W-1:0]       res;

  assign v_bias = {{(V_W - PROD_W){terms.m1[PROD_W-1]}}, terms.m1}
                + {{(V_W - PROD_W){terms.m2[PROD_W-1]}}, terms.m2}
                + {{(V_W - WORK_FRAC - FRAC_W){1'b0}}, terms.b3, {FRAC_W{1'b0}}}
                + ROUND_BIAS;
  assign rnd = v_bias[V_W-1:WORK_FRAC];

  always_comb begin
    if (rnd > OUT_MAX) begin
      sat = OUT_MAX[PROG_W-1:0];
    end else if (rnd < OUT_MIN) begin
      sat = OUT_MIN[PROG_W-1:0];
    end else begin
      sat = rnd[PROG_W-1:0];
    end
    case (ctl_d[CE_LAT-1].cls)
      CLS_ZERO: res = '0;
      CLS_ONE:  res = EASED_ONE;
      default:  res = sat;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_d[CE_LAT-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    eased_out <= res;
  end

endmodule
`default_nettype wire

[hw/rtl/cubic_bezier_easing_solver_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bezier_easing_solver_top
// Eases a linear progress value through a cubic-bezier timing curve with
// end points (0,0) and (1,1), found by bisection on the curve parameter.
//
//   channel   signals                                  direction
//   input     start, busy, progress_in                 in (busy out)
//   result    done, eased_out                          out
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data in (cfg_ready out)
//
// A new item may be started in every cycle; busy stays low.
// done rises after the input register, four stages per bisection step and four
// in the final y evaluation; eased_out is registered alongside done.
// Reset clears only the valid pipeline and the control registers.
// Results are strobed by done for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module cubic_bezier_easing_solver_top #(
  parameter int BISECT_STEPS    = cbe_pkg::BISECT_STEPS_DEF,
  parameter int PARAM_FRAC_BITS = cbe_pkg::PARAM_FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [cbe_pkg::PROG_W-1:0]  progress_in,
  output logic                             done,
  output logic [cbe_pkg::PROG_W-1:0]       eased_out,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [cbe_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [cbe_pkg::CFG_W-1:0]   cfg_data
);
  import cbe_pkg::*;

  localparam int PFB = PARAM_FRAC_BITS;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Control coefficients, held as three times each control coordinate.
  cbe_coef_t kx1;
  cbe_coef_t ky1;
  cbe_coef_t kx2;
  cbe_coef_t ky2;

  always_ff @(posedge clk) begin
    if (rst) begin
      kx1 <= KX1_RST;
      ky1 <= KY1_RST;
      kx2 <= KX2_RST;
      ky2 <= KY2_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cbe_reg_e'(cfg_index))
        REG_CTRL_X1: kx1 <= cbe_triple_x(cfg_data);
        REG_CTRL_Y1: ky1 <= cbe_triple_y(cfg_data);
        REG_CTRL_X2: kx2 <= cbe_triple_x(cfg_data);
        REG_CTRL_Y2: ky2 <= cbe_triple_y(cfg_data);
      endcase
    end
  end

  // Input register: classify the progress value.
  cbe_ctl_t          in_ctl;
  cbe_ctl_t          in_ctl_next;
  logic [FRAC_W-1:0] in_p;

  always_comb begin
    in_ctl_next.valid = start && !busy;
    if (progress_in[PROG_W-1] || (progress_in == '0)) begin
      in_ctl_next.cls = CLS_ZERO;
    end else if (progress_in[FRAC_W]) begin
      in_ctl_next.cls = CLS_ONE;
    end else begin
      in_ctl_next.cls = CLS_CURVE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_ctl <= '0;
    end else begin
      in_ctl <= in_ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    in_p <= progress_in[FRAC_W-1:0];
  end

  // Chain of bisection steps.
  cbe_ctl_t          ch_ctl [BISECT_STEPS+1];
  logic [FRAC_W-1:0] ch_p   [BISECT_STEPS+1];
  logic [PFB:0]      ch_lo  [BISECT_STEPS+1];
  logic [PFB:0]      ch_hi  [BISECT_STEPS+1];

  assign ch_ctl[0] = in_ctl;
  assign ch_p[0]   = in_p;
  assign ch_lo[0]  = '0;
  assign ch_hi[0]  = {1'b1, {PFB{1'b0}}};

  for (genvar s = 0; s < BISECT_STEPS; s++) begin : g_step
    cbe_bisect_step #(
      .PFB (PFB)
    ) u_step (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ch_ctl[s]),
      .p_in    (ch_p[s]),
      .lo_in   (ch_lo[s]),
      .hi_in   (ch_hi[s]),
      .k1      (kx1),
      .k2      (kx2),
      .ctl_out (ch_ctl[s+1]),
      .p_out   (ch_p[s+1]),
      .lo_out  (ch_lo[s+1]),
      .hi_out  (ch_hi[s+1])
    );
  end

  cbe_finish #(
    .PFB (PFB)
  ) u_finish (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (ch_ctl[BISECT_STEPS]),
    .lo_in     (ch_lo[BISECT_STEPS]),
    .hi_in     (ch_hi[BISECT_STEPS]),
    .k1        (ky1),
    .k2        (ky2),
    .done      (done),
    .eased_out (eased_out)
  );

endmodule
`default_nettype wire
